### sv/byte_capacity_lru_cache_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the byte capacity LRU cache
// Shared concurrent check forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BYTE_CAPACITY_LRU_CACHE_UNIT_DEFINES_SVH
`define BYTE_CAPACITY_LRU_CACHE_UNIT_DEFINES_SVH

// same-cycle implication
`define BLRU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BLRU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/blru_pkg.sv
// ----------------------------------------------------------------------------
// blru_pkg
// Widths, codes and sequencer states of the byte capacity LRU cache.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package blru_pkg;

    localparam int CAP_W   = 36;
    localparam int SIZE_W  = 32;
    localparam int CNT_O_W = 7;

    localparam logic [CAP_W-1:0] CAP_RESET = 36'd268435456;

    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_INSERT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TOUCH_RD,
        ST_TOUCH_A,
        ST_TOUCH_B,
        ST_EVICT_CHK,
        ST_EVICT_UPD,
        ST_INSERT,
        ST_DONE
    } state_t;

endpackage

### sv/blru_req_if.sv
// ----------------------------------------------------------------------------
// blru_req_if
// Request channel: valid/ready with action, key and item size.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface blru_req_if #(
    parameter int KEY_BITS = 16
);
    import blru_pkg::*;

    logic                valid;
    logic                ready;
    logic                action;
    logic [KEY_BITS-1:0] content_key;
    logic [SIZE_W-1:0]   item_size;

    modport source (output valid, action, content_key, item_size, input ready);
    modport sink   (input valid, action, content_key, item_size, output ready);
endinterface

### sv/blru_rsp_if.sv
// ----------------------------------------------------------------------------
// blru_rsp_if
// Result channel: valid/ready with hit, insert and occupancy fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface blru_rsp_if;
    import blru_pkg::*;

    logic               valid;
    logic               ready;
    logic               was_present;
    logic               was_inserted;
    logic [CNT_O_W-1:0] evicted_count;
    logic [CAP_W-1:0]   bytes_used;
    logic [CNT_O_W-1:0] entries_held;

    modport source (output valid, was_present, was_inserted, evicted_count, bytes_used,
                    entries_held, input ready);
    modport sink   (input valid, was_present, was_inserted, evicted_count, bytes_used,
                    entries_held, output ready);
endinterface

### sv/blru_ram.sv
// ----------------------------------------------------------------------------
// blru_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module blru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### sv/byte_capacity_lru_cache_unit.sv
// ----------------------------------------------------------------------------
// byte_capacity_lru_cache_unit
// Size-bounded LRU cache of content keys, one request at a time.
// ----------------------------------------------------------------------------
// One request is handled at a time. A request walks the tag slots through the
// key RAM, one slot a cycle, and stops at a hit; a miss walks all MAX_ENTRIES
// slots. A hit that is not already most-recent passes through ST_TOUCH_RD,
// ST_TOUCH_A and ST_TOUCH_B to relink it at the head of the recency list, and
// an insert of a new key passes ST_EVICT_CHK and ST_EVICT_UPD per evicted entry,
// then a last check and, if the item fits, the write in ST_INSERT.
// Recency is a doubly linked list kept in two pointer RAMs; valid bits are
// flip-flops cleared at reset, so no clearing pass is needed. A new request is
// taken while the previous result still waits in the output register.
`timescale 1ns / 1ps

`include "byte_capacity_lru_cache_unit_defines.svh"

module byte_capacity_lru_cache_unit #(
    parameter int MAX_ENTRIES = 64,
    parameter int KEY_BITS    = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [blru_pkg::CAP_W-1:0] cfg_wdata,
    blru_req_if.sink                  req,
    blru_rsp_if.source                rsp
);
    import blru_pkg::*;

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ENTRIES - 1);

    state_t state_reg, state_next;

    logic [CAP_W-1:0]    cap_reg;
    logic                act_reg, act_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [IW-1:0]       scan_idx_reg, scan_idx_next;
    logic [IW-1:0]       rd_idx_reg, rd_idx_next;
    logic                pend_reg, pend_next;
    logic [IW-1:0]       hit_reg, hit_next;
    logic                present_reg, present_next;
    logic                inserted_reg, inserted_next;
    logic [IW-1:0]       free_reg, free_next;
    logic                free_ok_reg, free_ok_next;
    logic [CW-1:0]       evict_cnt_reg, evict_cnt_next;
    logic [IW-1:0]       head_reg, head_next;
    logic [IW-1:0]       tail_reg, tail_next;
    logic [CAP_W-1:0]    used_reg, used_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [MAX_ENTRIES-1:0] valid_reg, valid_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_present_reg, out_inserted_reg;
    logic [CNT_O_W-1:0] out_evicted_reg, out_held_reg;
    logic [CAP_W-1:0]   out_used_reg;
    logic               out_load;

    // RAM ports
    logic [IW-1:0]       rd_addr;
    logic [KEY_BITS-1:0] key_rd;
    logic [SIZE_W-1:0]   size_rd;
    logic [IW-1:0]       prev_rd, next_rd;
    logic                key_we, size_we, prev_we, next_we;
    logic [IW-1:0]       key_wa, size_wa, prev_wa, next_wa;
    logic [IW-1:0]       prev_wd, next_wd;

    logic match;
    logic evict_cond;
    logic size_fits;

    assign match      = pend_reg && valid_reg[rd_idx_reg] && (key_rd == key_reg);
    assign size_fits  = {4'd0, size_reg} <= cap_reg;
    assign evict_cond = (count_reg != '0) &&
                        (({1'b0, used_reg} + {5'd0, size_reg} > {1'b0, cap_reg}) ||
                         (count_reg >= CW'(MAX_ENTRIES)));
    assign out_load   = (state_reg == ST_DONE) && (!out_valid_reg || rsp.ready);

    blru_ram #(.WIDTH(KEY_BITS), .DEPTH(MAX_ENTRIES)) u_key_ram (
        .clk(clk), .we(key_we), .waddr(key_wa), .wdata(key_reg),
        .raddr(rd_addr), .rdata(key_rd)
    );

    blru_ram #(.WIDTH(SIZE_W), .DEPTH(MAX_ENTRIES)) u_size_ram (
        .clk(clk), .we(size_we), .waddr(size_wa), .wdata(size_reg),
        .raddr(rd_addr), .rdata(size_rd)
    );

    blru_ram #(.WIDTH(IW), .DEPTH(MAX_ENTRIES)) u_prev_ram (
        .clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
        .raddr(rd_addr), .rdata(prev_rd)
    );

    blru_ram #(.WIDTH(IW), .DEPTH(MAX_ENTRIES)) u_next_ram (
        .clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
        .raddr(rd_addr), .rdata(next_rd)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (match)
                begin
                    state_next = (rd_idx_reg == head_reg) ? ST_DONE : ST_TOUCH_RD;
                end
                else if (pend_reg && (rd_idx_reg == LAST_IDX))
                begin
                    state_next = (act_reg == ACT_INSERT) ? ST_EVICT_CHK : ST_DONE;
                end
            end
            ST_TOUCH_RD:  state_next = ST_TOUCH_A;
            ST_TOUCH_A:   state_next = ST_TOUCH_B;
            ST_TOUCH_B:   state_next = ST_DONE;
            ST_EVICT_CHK:
            begin
                if (evict_cond)
                begin
                    state_next = ST_EVICT_UPD;
                end
                else if (size_fits)
                begin
                    state_next = ST_INSERT;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_EVICT_UPD: state_next = ST_EVICT_CHK;
            ST_INSERT:    state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb
    begin
        act_next       = act_reg;
        key_next       = key_reg;
        size_next      = size_reg;
        scan_idx_next  = scan_idx_reg;
        rd_idx_next    = rd_idx_reg;
        pend_next      = pend_reg;
        hit_next       = hit_reg;
        present_next   = present_reg;
        inserted_next  = inserted_reg;
        free_next      = free_reg;
        free_ok_next   = free_ok_reg;
        evict_cnt_next = evict_cnt_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        used_next      = used_reg;
        count_next     = count_reg;
        valid_next     = valid_reg;
        rd_addr        = scan_idx_reg;
        key_we  = 1'b0;
        size_we = 1'b0;
        prev_we = 1'b0;
        next_we = 1'b0;
        key_wa  = free_reg;
        size_wa = free_reg;
        prev_wa = head_reg;
        next_wa = free_reg;
        prev_wd = free_reg;
        next_wd = head_reg;
        req.ready = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    act_next       = req.action;
                    key_next       = req.content_key;
                    size_next      = req.item_size;
                    scan_idx_next  = '0;
                    pend_next      = 1'b0;
                    present_next   = 1'b0;
                    inserted_next  = 1'b0;
                    free_ok_next   = 1'b0;
                    evict_cnt_next = '0;
                end
            end
            ST_SCAN:
            begin
                rd_addr     = scan_idx_reg;
                pend_next   = 1'b1;
                rd_idx_next = scan_idx_reg;
                if (scan_idx_reg != LAST_IDX)
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                // lowest free slot seen so far
                if (pend_reg && !valid_reg[rd_idx_reg] && !free_ok_reg)
                begin
                    free_next    = rd_idx_reg;
                    free_ok_next = 1'b1;
                end
                if (match)
                begin
                    hit_next     = rd_idx_reg;
                    present_next = 1'b1;
                end
            end
            ST_TOUCH_RD:
            begin
                rd_addr = hit_reg;
            end
            ST_TOUCH_A:
            begin
                // unlink: next[prev] = next, prev[next] = prev
                next_we = 1'b1;
                next_wa = prev_rd;
                next_wd = next_rd;
                if (hit_reg == tail_reg)
                begin
                    tail_next = prev_rd;
                end
                else
                begin
                    prev_we = 1'b1;
                    prev_wa = next_rd;
                    prev_wd = prev_rd;
                end
            end
            ST_TOUCH_B:
            begin
                next_we   = 1'b1;
                next_wa   = hit_reg;
                next_wd   = head_reg;
                prev_we   = 1'b1;
                prev_wa   = head_reg;
                prev_wd   = hit_reg;
                head_next = hit_reg;
            end
            ST_EVICT_CHK:
            begin
                rd_addr = tail_reg;
            end
            ST_EVICT_UPD:
            begin
                valid_next[tail_reg] = 1'b0;
                used_next      = used_reg - {4'd0, size_rd};
                count_next     = count_reg - 1'b1;
                evict_cnt_next = evict_cnt_reg + 1'b1;
                tail_next      = prev_rd;
                if (!free_ok_reg || (tail_reg < free_reg))
                begin
                    free_next    = tail_reg;
                    free_ok_next = 1'b1;
                end
            end
            ST_INSERT:
            begin
                key_we  = 1'b1;
                size_we = 1'b1;
                next_we = 1'b1;
                next_wa = free_reg;
                next_wd = head_reg;
                if (count_reg != '0)
                begin
                    prev_we = 1'b1;
                    prev_wa = head_reg;
                    prev_wd = free_reg;
                end
                else
                begin
                    tail_next = free_reg;
                end
                head_next            = free_reg;
                valid_next[free_reg] = 1'b1;
                used_next            = used_reg + {4'd0, size_reg};
                count_next           = count_reg + 1'b1;
                inserted_next        = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid_next = (out_valid_reg && !rsp.ready) || out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= CAP_RESET;
            valid_reg     <= '0;
            used_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            free_ok_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            used_reg      <= used_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            free_ok_reg   <= free_ok_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        key_reg       <= key_next;
        size_reg      <= size_next;
        scan_idx_reg  <= scan_idx_next;
        rd_idx_reg    <= rd_idx_next;
        hit_reg       <= hit_next;
        present_reg   <= present_next;
        inserted_reg  <= inserted_next;
        free_reg      <= free_next;
        evict_cnt_reg <= evict_cnt_next;
        head_reg      <= head_next;
        tail_reg      <= tail_next;
        if (out_load)
        begin
            out_present_reg  <= present_reg;
            out_inserted_reg <= inserted_reg;
            out_evicted_reg  <= CNT_O_W'({{CNT_O_W{1'b0}}, evict_cnt_reg});
            out_used_reg     <= used_reg;
            out_held_reg     <= CNT_O_W'({{CNT_O_W{1'b0}}, count_reg});
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.was_present   = out_present_reg;
    assign rsp.was_inserted  = out_inserted_reg;
    assign rsp.evicted_count = out_evicted_reg;
    assign rsp.bytes_used    = out_used_reg;
    assign rsp.entries_held  = out_held_reg;

    `BLRU_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(MAX_ENTRIES), "entry count overflow")
    `BLRU_ASSERT_NOW(a_empty_no_bytes, count_reg == '0, used_reg == '0, "bytes held with no entries")
    `BLRU_ASSERT_NOW(a_insert_slot, state_reg == ST_INSERT, free_ok_reg && !valid_reg[free_reg], "insert without free slot")
    `BLRU_ASSERT_NEXT(a_evict_dec, state_reg == ST_EVICT_UPD, count_reg == $past(count_reg) - 1'b1, "eviction did not drop count")
endmodule

### verif/byte_capacity_lru_cache_unit_tb.sv
// ----------------------------------------------------------------------------
// byte_capacity_lru_cache_unit_tb
// Drives lookups and inserts with random gaps and stalls on both channels.
// A behavioral LRU predictor checks every result beat field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module byte_capacity_lru_cache_unit_tb;
    import blru_pkg::*;

    localparam int NSLOT = 64;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic               was_present;
        logic               was_inserted;
        logic [CNT_O_W-1:0] evicted_count;
        logic [CAP_W-1:0]   bytes_used;
        logic [CNT_O_W-1:0] entries_held;
    } lru_result_t;

    // behavioral cache: slot table plus recency ranks, 0 = most recent
    class lru_scoreboard;
        logic [CAP_W-1:0]  capacity;
        logic [15:0]       keys  [NSLOT];
        logic [SIZE_W-1:0] sizes [NSLOT];
        bit                held  [NSLOT];
        int                rank  [NSLOT];
        logic [CAP_W-1:0]  used;
        int                count;
        lru_result_t       pending[$];
        int                errors;

        function void clear();
            capacity = CAP_RESET;
            used = '0;
            count = 0;
            errors = 0;
            foreach (held[i])
            begin
                held[i] = 0;
                rank[i] = 0;
            end
        endfunction

        function void note_request(logic act, logic [15:0] key, logic [SIZE_W-1:0] sz);
            lru_result_t r;
            int hit;
            int old;
            int evicted;
            hit = -1;
            evicted = 0;
            r = '0;
            for (int i = 0; i < NSLOT; i++)
                if (held[i] && keys[i] == key)
                    hit = i;
            if (hit >= 0)
            begin
                r.was_present = 1'b1;
                old = rank[hit];
                for (int i = 0; i < NSLOT; i++)
                    if (held[i] && rank[i] < old)
                        rank[i]++;
                rank[hit] = 0;
            end
            else if (act == ACT_INSERT)
            begin
                while (count > 0 &&
                       ({5'b0, sz} + {1'b0, used} > {1'b0, capacity} || count >= NSLOT))
                begin
                    for (int i = 0; i < NSLOT; i++)
                        if (held[i] && rank[i] == count - 1)
                        begin
                            held[i] = 0;
                            used -= sizes[i];
                            count--;
                            break;
                        end
                    evicted++;
                end
                if ({4'b0, sz} <= capacity)
                    for (int i = 0; i < NSLOT; i++)
                        if (!held[i])
                        begin
                            for (int j = 0; j < NSLOT; j++)
                                if (held[j])
                                    rank[j]++;
                            held[i] = 1;
                            keys[i] = key;
                            sizes[i] = sz;
                            rank[i] = 0;
                            used += sz;
                            count++;
                            r.was_inserted = 1'b1;
                            break;
                        end
            end
            r.evicted_count = CNT_O_W'(evicted);
            r.bytes_used = used;
            r.entries_held = CNT_O_W'(count);
            pending = {pending, r};
        endfunction

        function void check_result(lru_result_t got);
            lru_result_t exp;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result beat, actual %p", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.was_present !== exp.was_present)
            begin
                $display("%0t: was_present expected %0d actual %0d", $time,
                         exp.was_present, got.was_present);
                errors++;
            end
            if (got.was_inserted !== exp.was_inserted)
            begin
                $display("%0t: was_inserted expected %0d actual %0d", $time,
                         exp.was_inserted, got.was_inserted);
                errors++;
            end
            if (got.evicted_count !== exp.evicted_count)
            begin
                $display("%0t: evicted_count expected %0d actual %0d", $time,
                         exp.evicted_count, got.evicted_count);
                errors++;
            end
            if (got.bytes_used !== exp.bytes_used)
            begin
                $display("%0t: bytes_used expected %0d actual %0d", $time,
                         exp.bytes_used, got.bytes_used);
                errors++;
            end
            if (got.entries_held !== exp.entries_held)
            begin
                $display("%0t: entries_held expected %0d actual %0d", $time,
                         exp.entries_held, got.entries_held);
                errors++;
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CAP_W-1:0] cfg_wdata;
    longint           cycles;
    int               hold_off;   // >0: receiver stall length, then cleared
    bit               stop_rx;

    blru_req_if #(.KEY_BITS(16)) req ();
    blru_rsp_if                  rsp ();

    lru_scoreboard sb;

    byte_capacity_lru_cache_unit #(.MAX_ENTRIES(NSLOT), .KEY_BITS(16)) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .req      (req.sink),
        .rsp      (rsp.source)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result side: sample at rising edge, change ready at falling edge
    initial
    begin
        int gap;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (hold_off) @(negedge clk);
                hold_off = 0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            if ($urandom_range(0, 2) == 0)
                gap = 0;
            if (gap > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp.valid);
            sb.check_result({rsp.was_present, rsp.was_inserted, rsp.evicted_count,
                             rsp.bytes_used, rsp.entries_held});
        end
    end

    bit burst_mode;

    // valid stays up after a beat until the next gap or drain drops it
    task automatic send_request(logic act, logic [15:0] key, logic [SIZE_W-1:0] sz);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 15);
        if (!burst_mode && $urandom_range(0, 2) == 0)
            gap = 0;
        if (gap > 0)
        begin
            req.valid       <= 1'b0;
            req.action      <= 1'($urandom);
            req.content_key <= 16'($urandom);
            req.item_size   <= $urandom;
            repeat (gap) @(negedge clk);
        end
        req.valid       <= 1'b1;
        req.action      <= act;
        req.content_key <= key;
        req.item_size   <= sz;
        do
            @(posedge clk);
        while (!req.ready);
        sb.note_request(act, key, sz);
        @(negedge clk);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        // an item with no result does not exist here, but let the walk settle
        repeat (200) @(negedge clk);
    endtask

    task automatic set_capacity(logic [CAP_W-1:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.capacity = value;
    endtask

    // mostly small key pool so hits and refreshes are common
    task automatic random_phase(int n, int pool, logic [SIZE_W-1:0] max_size);
        logic [15:0]       key;
        logic [SIZE_W-1:0] sz;
        for (int k = 0; k < n; k++)
        begin
            key = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, pool));
            case ($urandom_range(0, 9))
                0:       sz = $urandom;
                1:       sz = 0;
                default: sz = $urandom_range(0, max_size);
            endcase
            send_request($urandom_range(0, 9) < 6 ? ACT_INSERT : ACT_LOOKUP, key, sz);
        end
    endtask

    initial
    begin
        sb = new();
        sb.clear();
        cycles = 0;
        hold_off = 0;
        burst_mode = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req.valid = 1'b0;
        req.action = ACT_LOOKUP;
        req.content_key = '0;
        req.item_size = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: miss, inserts, hit, refresh, zero size, oversize, extremes
        send_request(ACT_LOOKUP, 16'h0000, 32'hFFFF_FFFF);
        send_request(ACT_INSERT, 16'h0000, 32'd100);
        send_request(ACT_INSERT, 16'hFFFF, 32'd0);
        send_request(ACT_INSERT, 16'h1234, 32'd200);
        send_request(ACT_LOOKUP, 16'h0000, 32'd0);
        send_request(ACT_INSERT, 16'hFFFF, 32'd5000);
        send_request(ACT_LOOKUP, 16'h5555, 32'd1);
        send_request(ACT_INSERT, 16'hAAAA, 32'h0FFF_FF00);
        send_request(ACT_INSERT, 16'h5555, 32'hFFFF_FFFF);
        send_request(ACT_LOOKUP, 16'hAAAA, 32'd0);
        send_request(ACT_INSERT, 16'h0001, 32'h1000_0000);

        // full table: 70 distinct small keys
        for (int k = 0; k < 70; k++)
            send_request(ACT_INSERT, 16'(16'h0100 + k), 32'(k));
        send_request(ACT_LOOKUP, 16'h0107, 32'd0);
        send_request(ACT_LOOKUP, 16'h0100, 32'd0);

        // lower capacity under bytes held, then insert restores the bound
        set_capacity(36'd1000);
        send_request(ACT_LOOKUP, 16'h0140, 32'd0);
        send_request(ACT_INSERT, 16'h0200, 32'd10);
        set_capacity(36'd0);
        send_request(ACT_INSERT, 16'h0201, 32'd0);
        send_request(ACT_INSERT, 16'h0202, 32'd1);

        set_capacity(36'd5000);
        random_phase(300, 40, 32'd600);

        // input backs up while the receiver stalls
        drain();
        burst_mode = 1;
        hold_off = 400;
        random_phase(30, 40, 32'd600);
        burst_mode = 0;
        drain();

        set_capacity({CAP_W{1'b1}});
        random_phase(250, 100, 32'hFFFF_FFFF);
        set_capacity(36'd64);
        random_phase(250, 30, 32'd8);
        set_capacity(CAP_RESET);
        random_phase(250, 120, 32'h00FF_FFFF);
        set_capacity(36'd2000);
        random_phase(150, 60, 32'd300);

        drain();
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

### byte_capacity_lru_cache_unit.f
+incdir+sv
sv/blru_pkg.sv
sv/blru_req_if.sv
sv/blru_rsp_if.sv
sv/blru_ram.sv
sv/byte_capacity_lru_cache_unit.sv
verif/byte_capacity_lru_cache_unit_tb.sv
